// ===== src/rbb_pkg.sv =====
// Shared types, constants and helper functions for the raw10 Bayer binning to YUYV unit.
// No dependencies; imported by every module of the block but rbb_ram.

package rbb_pkg;

    // Transfer kinds on the input channel (s_tuser)
    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_GAMMA = 2'd1;
    localparam logic [1:0] MODE_STATS = 2'd2;

    // Result kinds on the output channel (m_tuser)
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_STATS = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_BAYER_ORDER = 2'd0;
    localparam logic [1:0] REG_RED_GAIN    = 2'd1;
    localparam logic [1:0] REG_GREEN_GAIN  = 2'd2;
    localparam logic [1:0] REG_BLUE_GAIN   = 2'd3;

    // Bayer arrangements
    localparam logic [1:0] ORDER_RGGB = 2'd0;
    localparam logic [1:0] ORDER_GRBG = 2'd1;
    localparam logic [1:0] ORDER_BGGR = 2'd2;
    localparam logic [1:0] ORDER_GBRG = 2'd3;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int GAIN_W      = 16;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

    localparam int SAMPLE_W    = 10;
    localparam int GROUP_W     = 40;
    localparam int PAIR_W      = 2 * SAMPLE_W;
    localparam int PROD_W      = SAMPLE_W + GAIN_W;
    localparam int GAIN_FRAC   = 12;
    localparam int GAMMA_DEPTH = 1024;
    localparam int GAMMA_AW    = 10;
    localparam int PIX_W       = 8;
    localparam int CSUM_W      = 18;
    localparam int TOTAL_W     = 40;
    localparam int SUM_WIDTH_DEF = 40;

    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 160;

    // Colour conversion coefficients
    localparam int Y_R = 77;
    localparam int Y_G = 150;
    localparam int Y_B = 29;
    localparam int U_R = -43;
    localparam int U_G = -85;
    localparam int U_B = 128;
    localparam int V_R = 128;
    localparam int V_G = -107;
    localparam int V_B = -21;
    localparam logic [PIX_W-1:0] CHROMA_OFS = 8'd128;

    typedef struct packed {
        logic [GAIN_W-1:0] red;
        logic [GAIN_W-1:0] green;
        logic [GAIN_W-1:0] blue;
    } gains_t;

    typedef struct packed {
        logic                en;
        logic [GAMMA_AW-1:0] index;
        logic [PIX_W-1:0]    value;
    } gamma_wr_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] r;
        logic [SAMPLE_W-1:0] g;
        logic [SAMPLE_W-1:0] b;
    } cell_raw_t;

    typedef struct packed {
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] v;
    } cell_yuv_t;

    typedef struct packed {
        logic               kind;
        logic [PIX_W-1:0]   luma_first;
        logic [PIX_W-1:0]   chroma_blue;
        logic [PIX_W-1:0]   luma_second;
        logic [PIX_W-1:0]   chroma_red;
        logic [1:0]         pixel_count;
        logic [TOTAL_W-1:0] total_red;
        logic [TOTAL_W-1:0] total_green;
        logic [TOTAL_W-1:0] total_blue;
    } result_t;

    // Q14.12 product (sample times Q4.12 gain) back to a 10-bit level, clamped to full scale
    function automatic logic [GAMMA_AW-1:0] gain_clamp(input logic [PROD_W-1:0] prod);
        logic [GAMMA_AW-1:0] lvl;
        if (|prod[PROD_W-1:GAIN_FRAC+GAMMA_AW]) begin
            lvl = '1;
        end else begin
            lvl = prod[GAIN_FRAC+GAMMA_AW-1:GAIN_FRAC];
        end
        return lvl;
    endfunction

    // floor(v / 256) + ofs, clamped to 0..255
    function automatic logic [PIX_W-1:0] shift_clamp(input logic signed [CSUM_W-1:0] v,
                                                     input logic [PIX_W-1:0] ofs);
        logic signed [CSUM_W-9:0] sh;
        logic signed [CSUM_W-7:0] q;
        logic [PIX_W-1:0]         res;
        sh = $signed(v[CSUM_W-1:8]);
        q  = $signed({{2{sh[CSUM_W-9]}}, sh}) + $signed({4'b0000, ofs});
        if (q[CSUM_W-7]) begin
            res = '0;
        end else if (|q[CSUM_W-8:PIX_W]) begin
            res = '1;
        end else begin
            res = q[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== src/raw10_bayer_bin_to_yuyv_unit.sv =====
// Raw10 Bayer 2x2 binning to YUYV: top level with stream ports, config and sequencing.
// Depends on rbb_pkg, rbb_lane, rbb_merge (and rbb_ram through the lanes).
//
// Usage:
//   The s_ channel carries one transfer per item; s_tuser selects pixel pair, gamma
//   table write or statistics readout. A pixel pair carries one packed 5-byte group
//   from each row of a row pair; two lanes bin one 2x2 cell each in parallel and the
//   merge stage sums raw colours and builds the Y0 U Y1 V result. A readout returns
//   the three colour sums and clears them. Gamma writes and unused kinds give no result.
//   Items are taken one at a time; each item walks the gain multiply, the gamma
//   RAM read, the colour sum and the output stage before s_tready rises again.
//   The output register lets the next item in while a result waits; if the receiver
//   stalls, that next item holds in the last stage and s_tready stays low until the
//   waiting result is taken. Reset clears the sums, the config registers (RGGB, unity
//   gains) and the handshake state. The gamma table is not cleared: every entry in use
//   must be written first. Config is written through cfg_wr_en/cfg_index/cfg_wdata;
//   the user must do so only while the block is idle; the block does not enforce it.

module raw10_bayer_bin_to_yuyv_unit #(
    parameter int SUM_WIDTH = rbb_pkg::SUM_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write port
    input  logic                          cfg_wr_en,
    input  logic [rbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // even_row_group[39:0], odd_row_group[79:40], second_pixel_valid[80],
    // table_index[90:81], table_value[98:91], zero pad[103:99]
    input  logic [rbb_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [rbb_pkg::S_TUSER_W-1:0] s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24],
    // pixel_count[33:32], total_red[73:34], total_green[113:74], total_blue[153:114],
    // zero pad[159:154]
    output logic [rbb_pkg::M_TDATA_W-1:0] m_tdata,
    // result_kind[0]
    output logic                          m_tuser
);
    import rbb_pkg::*;

    // config
    logic [1:0] bayer_order_reg;
    gains_t     gains_reg;

    // sequencing
    logic busy_reg, busy_next;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v4_next;
    logic accept;
    logic has_result;
    logic done;

    // captured item
    logic [1:0]          mode_reg;
    logic [GROUP_W-1:0]  even_reg;
    logic [GROUP_W-1:0]  odd_reg;
    logic                second_reg;
    logic [GAMMA_AW-1:0] index_reg;
    logic [PIX_W-1:0]    value_reg;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    gamma_wr_t gamma_wr;
    cell_raw_t raw0, raw1;
    cell_yuv_t yuv0, yuv1;
    result_t   result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bayer_order_reg <= ORDER_RGGB;
            gains_reg.red   <= GAIN_UNITY;
            gains_reg.green <= GAIN_UNITY;
            gains_reg.blue  <= GAIN_UNITY;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BAYER_ORDER: bayer_order_reg <= cfg_wdata[1:0];
                REG_RED_GAIN:    gains_reg.red   <= cfg_wdata[GAIN_W-1:0];
                REG_GREEN_GAIN:  gains_reg.green <= cfg_wdata[GAIN_W-1:0];
                REG_BLUE_GAIN:   gains_reg.blue  <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready   = !busy_reg;
    assign accept     = s_tvalid && s_tready;
    assign has_result = (mode_reg == MODE_PIXEL) || (mode_reg == MODE_STATS);
    assign done       = v4_reg && (!has_result || !m_tvalid_reg || m_tready);

    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (done) begin
            busy_next = 1'b0;
        end
        v4_next = v4_reg;
        if (v3_reg) begin
            v4_next = 1'b1;
        end else if (done) begin
            v4_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg   <= s_tuser;
            even_reg   <= s_tdata[39:0];
            odd_reg    <= s_tdata[79:40];
            second_reg <= s_tdata[80];
            index_reg  <= s_tdata[90:81];
            value_reg  <= s_tdata[98:91];
        end
    end

    always_comb begin
        gamma_wr.en    = v1_reg && (mode_reg == MODE_GAMMA);
        gamma_wr.index = index_reg;
        gamma_wr.value = value_reg;
    end

    rbb_lane u_lane0 (
        .aclk        (aclk),
        .bayer_order (bayer_order_reg),
        .even_pair   (even_reg[PAIR_W-1:0]),
        .odd_pair    (odd_reg[PAIR_W-1:0]),
        .gains       (gains_reg),
        .gamma_wr    (gamma_wr),
        .sum_load    (v3_reg),
        .raw         (raw0),
        .yuv         (yuv0)
    );

    rbb_lane u_lane1 (
        .aclk        (aclk),
        .bayer_order (bayer_order_reg),
        .even_pair   (even_reg[2*PAIR_W-1:PAIR_W]),
        .odd_pair    (odd_reg[2*PAIR_W-1:PAIR_W]),
        .gains       (gains_reg),
        .gamma_wr    (gamma_wr),
        .sum_load    (v3_reg),
        .raw         (raw1),
        .yuv         (yuv1)
    );

    rbb_merge #(.SUM_WIDTH(SUM_WIDTH)) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .capture      (v1_reg),
        .mode         (mode_reg),
        .second_valid (second_reg),
        .raw0         (raw0),
        .raw1         (raw1),
        .yuv0         (yuv0),
        .yuv1         (yuv1),
        .result       (result)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (done && has_result) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (done && has_result) begin
            m_tuser_reg <= result.kind;
            m_tdata_reg <= {6'd0, result.total_blue, result.total_green, result.total_red,
                            result.pixel_count, result.chroma_red, result.luma_second,
                            result.chroma_blue, result.luma_first};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== src/rbb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module rbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/rbb_lane.sv =====
// One pixel lane: Bayer cell pick-out, white balance, gamma lookup and YUV conversion.
// Depends on rbb_pkg and rbb_ram.

module rbb_lane (
    input  logic                       aclk,
    input  logic [1:0]                 bayer_order,
    input  logic [rbb_pkg::PAIR_W-1:0] even_pair,
    input  logic [rbb_pkg::PAIR_W-1:0] odd_pair,
    input  rbb_pkg::gains_t            gains,
    input  rbb_pkg::gamma_wr_t         gamma_wr,
    input  logic                       sum_load,
    output rbb_pkg::cell_raw_t         raw,
    output rbb_pkg::cell_yuv_t         yuv
);
    import rbb_pkg::*;

    logic                rx;
    logic                red_odd;
    logic [PAIR_W-1:0]   red_row;
    logic [PAIR_W-1:0]   oth_row;
    logic [SAMPLE_W-1:0] q0, q1, q2, q3;
    logic [SAMPLE_W:0]   g_sum;

    logic [PROD_W-1:0]   prod_r_reg, prod_g_reg, prod_b_reg;
    logic [PIX_W-1:0]    gam_r, gam_g, gam_b;
    logic signed [CSUM_W-1:0] rs, gs, bs;
    logic signed [CSUM_W-1:0] y_sum_reg, u_sum_reg, v_sum_reg;
    logic signed [CSUM_W-1:0] y_sum_next, u_sum_next, v_sum_next;

    always_comb begin
        rx      = (bayer_order == ORDER_GRBG) || (bayer_order == ORDER_BGGR);
        red_odd = (bayer_order == ORDER_BGGR) || (bayer_order == ORDER_GBRG);
        red_row = red_odd ? odd_pair : even_pair;
        oth_row = red_odd ? even_pair : odd_pair;
        q0 = red_row[SAMPLE_W-1:0];
        q1 = red_row[PAIR_W-1:SAMPLE_W];
        q2 = oth_row[SAMPLE_W-1:0];
        q3 = oth_row[PAIR_W-1:SAMPLE_W];
        // B sits diagonally opposite R; the two greens fill the other corners
        raw.r = rx ? q1 : q0;
        raw.b = rx ? q2 : q3;
        g_sum = rx ? ({1'b0, q0} + {1'b0, q3}) : ({1'b0, q1} + {1'b0, q2});
        raw.g = g_sum[SAMPLE_W:1];
    end

    always_ff @(posedge aclk) begin
        prod_r_reg <= PROD_W'(raw.r) * PROD_W'(gains.red);
        prod_g_reg <= PROD_W'(raw.g) * PROD_W'(gains.green);
        prod_b_reg <= PROD_W'(raw.b) * PROD_W'(gains.blue);
    end

    rbb_ram #(.WIDTH(PIX_W), .DEPTH(GAMMA_DEPTH)) u_gamma_r (
        .aclk    (aclk),
        .wr_en   (gamma_wr.en),
        .wr_addr (gamma_wr.index),
        .wr_data (gamma_wr.value),
        .rd_addr (gain_clamp(prod_r_reg)),
        .rd_data (gam_r)
    );

    rbb_ram #(.WIDTH(PIX_W), .DEPTH(GAMMA_DEPTH)) u_gamma_g (
        .aclk    (aclk),
        .wr_en   (gamma_wr.en),
        .wr_addr (gamma_wr.index),
        .wr_data (gamma_wr.value),
        .rd_addr (gain_clamp(prod_g_reg)),
        .rd_data (gam_g)
    );

    rbb_ram #(.WIDTH(PIX_W), .DEPTH(GAMMA_DEPTH)) u_gamma_b (
        .aclk    (aclk),
        .wr_en   (gamma_wr.en),
        .wr_addr (gamma_wr.index),
        .wr_data (gamma_wr.value),
        .rd_addr (gain_clamp(prod_b_reg)),
        .rd_data (gam_b)
    );

    always_comb begin
        rs = $signed({{(CSUM_W-PIX_W){1'b0}}, gam_r});
        gs = $signed({{(CSUM_W-PIX_W){1'b0}}, gam_g});
        bs = $signed({{(CSUM_W-PIX_W){1'b0}}, gam_b});
        y_sum_next = CSUM_W'(Y_R * rs + Y_G * gs + Y_B * bs);
        u_sum_next = CSUM_W'(U_R * rs + U_G * gs + U_B * bs);
        v_sum_next = CSUM_W'(V_R * rs + V_G * gs + V_B * bs);
    end

    always_ff @(posedge aclk) begin
        if (sum_load) begin
            y_sum_reg <= y_sum_next;
            u_sum_reg <= u_sum_next;
            v_sum_reg <= v_sum_next;
        end
    end

    always_comb begin
        yuv.y = shift_clamp(y_sum_reg, '0);
        yuv.u = shift_clamp(u_sum_reg, CHROMA_OFS);
        yuv.v = shift_clamp(v_sum_reg, CHROMA_OFS);
    end

endmodule

// ===== src/rbb_merge.sv =====
// Merging stage: colour sums over both lanes, statistics readout and result assembly.
// Depends on rbb_pkg.

module rbb_merge #(
    parameter int SUM_WIDTH = rbb_pkg::SUM_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               capture,
    input  logic [1:0]         mode,
    input  logic               second_valid,
    input  rbb_pkg::cell_raw_t raw0,
    input  rbb_pkg::cell_raw_t raw1,
    input  rbb_pkg::cell_yuv_t yuv0,
    input  rbb_pkg::cell_yuv_t yuv1,
    output rbb_pkg::result_t   result
);
    import rbb_pkg::*;

    localparam int EXT_W = (SUM_WIDTH > TOTAL_W) ? SUM_WIDTH : TOTAL_W;

    logic [SUM_WIDTH-1:0] acc_r_reg, acc_g_reg, acc_b_reg;
    logic [SUM_WIDTH-1:0] acc_r_next, acc_g_next, acc_b_next;
    logic [TOTAL_W-1:0]   stat_r_reg, stat_g_reg, stat_b_reg;
    logic [EXT_W-1:0]     ext_r, ext_g, ext_b;

    // Both cells in one add: saturating twice equals saturating the total
    function automatic logic [SUM_WIDTH-1:0] sat_acc(input logic [SUM_WIDTH-1:0] acc,
                                                     input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b,
                                                     input logic use_b);
        logic [SUM_WIDTH:0] s;
        logic [SUM_WIDTH:0] inc;
        inc = (SUM_WIDTH+1)'(a) + (use_b ? (SUM_WIDTH+1)'(b) : '0);
        s   = {1'b0, acc} + inc;
        return s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
    endfunction

    always_comb begin
        acc_r_next = acc_r_reg;
        acc_g_next = acc_g_reg;
        acc_b_next = acc_b_reg;
        if (capture && mode == MODE_PIXEL) begin
            acc_r_next = sat_acc(acc_r_reg, raw0.r, raw1.r, second_valid);
            acc_g_next = sat_acc(acc_g_reg, raw0.g, raw1.g, second_valid);
            acc_b_next = sat_acc(acc_b_reg, raw0.b, raw1.b, second_valid);
        end else if (capture && mode == MODE_STATS) begin
            acc_r_next = '0;
            acc_g_next = '0;
            acc_b_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_r_reg <= '0;
            acc_g_reg <= '0;
            acc_b_reg <= '0;
        end else begin
            acc_r_reg <= acc_r_next;
            acc_g_reg <= acc_g_next;
            acc_b_reg <= acc_b_next;
        end
    end

    assign ext_r = EXT_W'(acc_r_reg);
    assign ext_g = EXT_W'(acc_g_reg);
    assign ext_b = EXT_W'(acc_b_reg);

    always_ff @(posedge aclk) begin
        if (capture && mode == MODE_STATS) begin
            stat_r_reg <= ext_r[TOTAL_W-1:0];
            stat_g_reg <= ext_g[TOTAL_W-1:0];
            stat_b_reg <= ext_b[TOTAL_W-1:0];
        end
    end

    always_comb begin
        result = '0;
        if (mode == MODE_STATS) begin
            result.kind        = KIND_STATS;
            result.total_red   = stat_r_reg;
            result.total_green = stat_g_reg;
            result.total_blue  = stat_b_reg;
        end else begin
            result.kind        = KIND_PIXEL;
            result.luma_first  = yuv0.y;
            result.chroma_blue = yuv0.u;
            result.luma_second = second_valid ? yuv1.y : '0;
            result.chroma_red  = second_valid ? yuv1.v : '0;
            result.pixel_count = second_valid ? 2'd2 : 2'd1;
        end
    end

endmodule

// ===== dv/raw10_bayer_bin_to_yuyv_unit_tb.sv =====
// Self-checking testbench for raw10_bayer_bin_to_yuyv_unit: streams packed Bayer groups,
// gamma table writes and sum readouts, predicts every YUYV/statistics transfer and checks it.
// Depends on rbb_pkg and the unit's RTL only.

module raw10_bayer_bin_to_yuyv_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbb_pkg::*;

    // sum width of the block under test
    localparam int SUM_BITS = 24;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RAND_PHASES = 4;
    localparam int PHASE_ITEMS = 40;
    localparam int HOLD_AT = 40;

    typedef struct packed {
        logic [1:0]  mode;
        logic [39:0] even_grp;
        logic [39:0] odd_grp;
        logic        spv;
        logic [9:0]  tbl_idx;
        logic [7:0]  tbl_val;
    } stim_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    raw10_bayer_bin_to_yuyv_unit #(
        .SUM_WIDTH(SUM_BITS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predictor state and register copy
    logic [7:0]  gamma_lut [GAMMA_DEPTH];
    logic [63:0] acc_red   = '0;
    logic [63:0] acc_green = '0;
    logic [63:0] acc_blue  = '0;
    logic [1:0]  cur_order  = ORDER_RGGB;
    logic [15:0] cur_gain_r = GAIN_UNITY;
    logic [15:0] cur_gain_g = GAIN_UNITY;
    logic [15:0] cur_gain_b = GAIN_UNITY;

    stim_t   raw_pending_q [$];
    result_t yuyv_expect_q [$];
    int      faults = 0;
    bit      tx_quiet = 1'b0;
    bit      rx_quiet = 1'b0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(64'd30_000_000);
        $display("FAIL raw10_bayer_bin_to_yuyv_unit");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [7:0] gain_gamma(input logic [9:0] raw, input logic [15:0] gain);
        logic [25:0] prod;
        logic [25:0] lvl;
        prod = 26'(raw) * 26'(gain);
        lvl  = prod >> GAIN_FRAC;
        if (lvl > 26'd1023)
            lvl = 26'd1023;
        return gamma_lut[lvl[9:0]];
    endfunction

    // floor shift by 8, add offset, clamp to a byte
    function automatic logic [7:0] clamp_byte(input int v, input int ofs);
        int q;
        q = (v >>> 8) + ofs;
        if (q < 0)
            q = 0;
        else if (q > 255)
            q = 255;
        return q[7:0];
    endfunction

    function automatic logic [63:0] sat_sum(input logic [63:0] acc, input logic [9:0] v);
        logic [63:0] top;
        top = (64'd1 << SUM_BITS) - 64'd1;
        if (acc > top - 64'(v))
            return top;
        return acc + 64'(v);
    endfunction

    // one 2x2 cell: samples of the red row and of the other row, columns 0 and 1
    function automatic void bin_cell(input logic [9:0] rrow0, rrow1, orow0, orow1,
                                     input bit rx, output logic [7:0] y, u, v);
        logic [9:0]  r, g, b;
        logic [10:0] gsum;
        int rv, gv, bv;
        r    = rx ? rrow1 : rrow0;
        b    = rx ? orow0 : orow1;
        gsum = {1'b0, rx ? rrow0 : rrow1} + {1'b0, rx ? orow1 : orow0};
        g    = gsum[10:1];
        acc_red   = sat_sum(acc_red, r);
        acc_green = sat_sum(acc_green, g);
        acc_blue  = sat_sum(acc_blue, b);
        rv = int'(gain_gamma(r, cur_gain_r));
        gv = int'(gain_gamma(g, cur_gain_g));
        bv = int'(gain_gamma(b, cur_gain_b));
        y = clamp_byte(Y_R * rv + Y_G * gv + Y_B * bv, 0);
        u = clamp_byte(U_R * rv + U_G * gv + U_B * bv, 128);
        v = clamp_byte(V_R * rv + V_G * gv + V_B * bv, 128);
    endfunction

    task automatic predict_transfer(input stim_t it);
        result_t     res;
        logic [39:0] top, bot;
        bit          rx;
        logic [7:0]  y0, u0, v0, y1, u1, v1;
        res = '0;
        case (it.mode)
            MODE_GAMMA: begin
                gamma_lut[it.tbl_idx] = it.tbl_val;
            end
            MODE_STATS: begin
                res.kind        = KIND_STATS;
                res.total_red   = acc_red[39:0];
                res.total_green = acc_green[39:0];
                res.total_blue  = acc_blue[39:0];
                acc_red   = '0;
                acc_green = '0;
                acc_blue  = '0;
                yuyv_expect_q.push_back(res);
            end
            MODE_PIXEL: begin
                rx = (cur_order == ORDER_GRBG) || (cur_order == ORDER_BGGR);
                if (cur_order == ORDER_BGGR || cur_order == ORDER_GBRG) begin
                    top = it.odd_grp;
                    bot = it.even_grp;
                end else begin
                    top = it.even_grp;
                    bot = it.odd_grp;
                end
                bin_cell(top[9:0], top[19:10], bot[9:0], bot[19:10], rx, y0, u0, v0);
                res.kind        = KIND_PIXEL;
                res.luma_first  = y0;
                res.chroma_blue = u0;
                res.pixel_count = 2'd1;
                if (it.spv) begin
                    bin_cell(top[29:20], top[39:30], bot[29:20], bot[39:30], rx, y1, u1, v1);
                    res.luma_second = y1;
                    res.chroma_red  = v1;
                    res.pixel_count = 2'd2;
                end
                yuyv_expect_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- driver

    function automatic int idle_gap(input bit quiet);
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 65)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 4);
        return $urandom_range(8, 40);
    endfunction

    stim_t on_bus;
    int    tx_gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap_left = 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_transfer(on_bus);
            if (!s_tvalid || s_tready) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    s_tvalid <= 1'b0;
                end else if (raw_pending_q.size() != 0) begin
                    on_bus = raw_pending_q.pop_front();
                    s_tdata  <= {5'd0, on_bus.tbl_val, on_bus.tbl_idx, on_bus.spv,
                                 on_bus.odd_grp, on_bus.even_grp};
                    s_tuser  <= on_bus.mode;
                    s_tvalid <= 1'b1;
                    tx_gap_left = idle_gap(tx_quiet);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    int rx_hold_left  = 0;
    int results_taken = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_taken++;
                // long hold-off so the output stage fills and s_tready drops
                if (results_taken == HOLD_AT)
                    rx_hold_left = 300;
            end
            if (rx_hold_left == 0 && !rx_quiet && $urandom_range(0, 199) == 0)
                rx_hold_left = $urandom_range(10, 40);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= rx_quiet || ($urandom_range(0, 99) < 70);
            end
        end
    end

    always @(posedge aclk) begin : yuyv_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind        = m_tuser;
            got.luma_first  = m_tdata[7:0];
            got.chroma_blue = m_tdata[15:8];
            got.luma_second = m_tdata[23:16];
            got.chroma_red  = m_tdata[31:24];
            got.pixel_count = m_tdata[33:32];
            got.total_red   = m_tdata[73:34];
            got.total_green = m_tdata[113:74];
            got.total_blue  = m_tdata[153:114];
            if (yuyv_expect_q.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: unexpected transfer kind=%0d", $realtime, got.kind);
            end else begin
                want = yuyv_expect_q.pop_front();
                if (got !== want) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("%0t: want k=%0d y0=%0d u=%0d y1=%0d v=%0d n=%0d R=%0d G=%0d B=%0d",
                                 $realtime, want.kind, want.luma_first, want.chroma_blue,
                                 want.luma_second, want.chroma_red, want.pixel_count,
                                 want.total_red, want.total_green, want.total_blue);
                        $display("%0t: got  k=%0d y0=%0d u=%0d y1=%0d v=%0d n=%0d R=%0d G=%0d B=%0d",
                                 $realtime, got.kind, got.luma_first, got.chroma_blue,
                                 got.luma_second, got.chroma_red, got.pixel_count,
                                 got.total_red, got.total_green, got.total_blue);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic stim_t px(input logic [39:0] even_grp, odd_grp, input logic spv);
        stim_t it;
        it.mode     = MODE_PIXEL;
        it.even_grp = even_grp;
        it.odd_grp  = odd_grp;
        it.spv      = spv;
        it.tbl_idx  = 10'($urandom_range(0, 1023));
        it.tbl_val  = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic stim_t gamma_write(input int idx, input int val);
        stim_t it;
        it          = px('0, '0, 1'b0);
        it.mode     = MODE_GAMMA;
        it.tbl_idx  = 10'(idx);
        it.tbl_val  = 8'(val);
        return it;
    endfunction

    function automatic logic [39:0] rand_group();
        logic [3:0][9:0] s;
        logic [63:0]     w;
        int              style, k, pick;
        style = $urandom_range(0, 9);
        w     = {$urandom, $urandom};
        s     = w[39:0];
        for (k = 0; k < 4; k++) begin
            if (style >= 8) begin
                s[k] = 10'($urandom_range(896, 1023));
            end else if (style >= 6) begin
                pick = $urandom_range(0, 2);
                s[k] = (pick == 0) ? 10'd0 : (pick == 1) ? 10'h3FF : s[k];
            end
        end
        return s;
    endfunction

    function automatic stim_t rand_item();
        stim_t it;
        int    pick;
        it      = px(rand_group(), rand_group(), $urandom_range(0, 9) < 8);
        pick    = $urandom_range(0, 99);
        if (pick < 78)
            it.mode = MODE_PIXEL;
        else if (pick < 86)
            it.mode = MODE_GAMMA;
        else if (pick < 94)
            it.mode = MODE_STATS;
        else
            it.mode = MODE_UNUSED;
        return it;
    endfunction

    function automatic logic [15:0] rand_gain();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'h0000;
        if (pick == 1)
            return 16'hFFFF;
        if (pick < 7)
            return 16'($urandom_range(2048, 8192));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic stim_t ctl(input logic [1:0] mode);
        stim_t it;
        it      = px(rand_group(), rand_group(), 1'($urandom_range(0, 1)));
        it.mode = mode;
        return it;
    endfunction

    // all four registers, back to back, block idle
    task automatic program_regs(input logic [1:0] order, input logic [15:0] rg, gg, bg);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BAYER_ORDER;
        cfg_wdata <= {14'd0, order};
        @(posedge aclk);
        cfg_index <= REG_RED_GAIN;
        cfg_wdata <= rg;
        @(posedge aclk);
        cfg_index <= REG_GREEN_GAIN;
        cfg_wdata <= gg;
        @(posedge aclk);
        cfg_index <= REG_BLUE_GAIN;
        cfg_wdata <= bg;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_order  = order;
        cur_gain_r = rg;
        cur_gain_g = gg;
        cur_gain_b = bg;
    endtask

    // gamma writes give no result, so allow the pipeline to drain after the last one
    task automatic wait_idle();
        while (raw_pending_q.size() != 0 || s_tvalid || yuyv_expect_q.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    initial begin : stimulus
        int n, ph;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        program_regs(ORDER_RGGB, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY);

        // whole table first, so no pixel ever reads an unwritten entry
        tx_quiet = 1'b1;
        for (n = 0; n < GAMMA_DEPTH; n++)
            raw_pending_q.push_back(gamma_write(n, (n == 0) ? 0 :
                                    (n == GAMMA_DEPTH - 1) ? 255 : $urandom_range(0, 255)));
        wait_idle();
        tx_quiet = 1'b0;

        // directed: black, full scale, half row, unused kind, readout and clear
        raw_pending_q.push_back(px('0, '0, 1'b1));
        raw_pending_q.push_back(px('1, '1, 1'b1));
        raw_pending_q.push_back(px(rand_group(), rand_group(), 1'b0));
        raw_pending_q.push_back(ctl(MODE_UNUSED));
        raw_pending_q.push_back(ctl(MODE_STATS));
        raw_pending_q.push_back(ctl(MODE_STATS));
        wait_idle();

        // gains at maximum: products of larger samples clamp to full scale
        program_regs(ORDER_GRBG, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        raw_pending_q.push_back(px('1, '1, 1'b1));
        raw_pending_q.push_back(px({10'd3, 10'd2, 10'd1, 10'd0}, {10'd7, 10'd6, 10'd5, 10'd4},
                                   1'b1));
        raw_pending_q.push_back(px(rand_group(), rand_group(), 1'b1));
        raw_pending_q.push_back(ctl(MODE_STATS));
        wait_idle();

        program_regs(ORDER_BGGR, 16'h0000, 16'h0000, 16'h0000);
        raw_pending_q.push_back(px(rand_group(), rand_group(), 1'b1));
        raw_pending_q.push_back(px('1, '1, 1'b0));
        raw_pending_q.push_back(ctl(MODE_STATS));
        wait_idle();

        program_regs(ORDER_GBRG, 16'h1800, 16'h1000, 16'h2000);
        raw_pending_q.push_back(gamma_write(GAMMA_DEPTH - 1, 0));
        raw_pending_q.push_back(px('1, '1, 1'b1));
        raw_pending_q.push_back(px(rand_group(), rand_group(), 1'b1));
        raw_pending_q.push_back(ctl(MODE_STATS));
        wait_idle();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            program_regs(ph[1:0], rand_gain(), rand_gain(), rand_gain());
            tx_quiet = (ph == 2);
            rx_quiet = (ph == 3);
            for (n = 0; n < PHASE_ITEMS; n++)
                raw_pending_q.push_back(rand_item());
            wait_idle();
        end
        repeat (20) @(posedge aclk);

        faults += yuyv_expect_q.size();
        if (faults == 0)
            $display("PASS raw10_bayer_bin_to_yuyv_unit");
        else
            $display("FAIL raw10_bayer_bin_to_yuyv_unit");
        $finish;
    end

endmodule

// ===== files.f =====
src/rbb_pkg.sv
src/rbb_ram.sv
src/rbb_lane.sv
src/rbb_merge.sv
src/raw10_bayer_bin_to_yuyv_unit.sv
dv/raw10_bayer_bin_to_yuyv_unit_tb.sv
